### sv/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared types, register indexes and sine-table helpers for the grid point generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

	localparam int unsigned COUNT_BITS = 10;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned TRIG_W  = 18;

	typedef enum logic [2:0] {
		MODE_BOX    = 3'd0,
		MODE_SPHERE = 3'd1,
		MODE_XY     = 3'd2,
		MODE_XZ     = 3'd3,
		MODE_YZ     = 3'd4
	} grid_mode_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_COUNTS   = 3'd1,
		REG_ORIGIN_X = 3'd2,
		REG_ORIGIN_Y = 3'd3,
		REG_ORIGIN_Z = 3'd4,
		REG_STEP_X   = 3'd5,
		REG_STEP_Y   = 3'd6,
		REG_STEP_Z   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic restart;
		logic [2:0] phase;
		logic emit;
	} gpg_cmd_t;

	typedef struct packed {
		logic done;
	} gpg_sts_t;

	// Quarter-wave sine entry for angle x (Q2.30 radians), Q1.16, Taylor series.
	function automatic logic [16:0] sine_entry(input longint x);
		longint term, sum, v;
		term = x;
		sum = x;
		for (int n = 1; n <= 6; n++) begin
			term = term * x / 64'sd1073741824;
			term = term * x / 64'sd1073741824;
			case (n)
				1: term = -term / 64'sd6;
				2: term = -term / 64'sd20;
				3: term = -term / 64'sd42;
				4: term = -term / 64'sd72;
				5: term = -term / 64'sd110;
				default: term = -term / 64'sd156;
			endcase
			sum = sum + term;
		end
		v = (sum >= 0) ? (sum + 8192) / 16384 : 0;
		if (v > 65536) begin
			v = 65536;
		end
		return v[16:0];
	endfunction

	// Half-away-from-zero rounded product of a signed value and a Q1.16 factor.
	function automatic logic signed [49:0] mul_round(input logic signed [49:0] a,
			input logic signed [TRIG_W-1:0] b);
		logic [49:0] ma;
		logic [16:0] mb;
		logic [66:0] p;
		logic neg;
		neg = a[49] ^ b[TRIG_W-1];
		ma = a[49] ? 50'(-a) : 50'(a);
		mb = b[TRIG_W-1] ? 17'(-b) : 17'(b);
		p = (67'(ma) * 67'(mb) + 67'd32768) >> 16;
		return neg ? -$signed(p[49:0]) : $signed(p[49:0]);
	endfunction

endpackage

### sv/gpg_ctrl.sv
// ----------------------------------------------------------------------------
// gpg_ctrl
// Sequencer: accepts a request, steps the datapath, holds the result.
// ----------------------------------------------------------------------------
module gpg_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_advance,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output gpg_pkg::gpg_cmd_t cmd,
	input  gpg_pkg::gpg_sts_t sts
);
	import gpg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_OUT  = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	state_t state_q;
	logic [2:0] phase_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_WAIT);

	always_comb begin
		cmd.start   = in_valid && in_ready;
		cmd.restart = in_valid && in_ready && !in_advance;
		cmd.phase   = phase_q;
		cmd.emit    = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CALC;
						phase_q <= '0;
					end
				end
				ST_CALC: begin
					phase_q <= phase_q + 3'd1;
					if (sts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/gpg_datapath.sv
// ----------------------------------------------------------------------------
// gpg_datapath
// Index counters, sine lookup, rounding multipliers and saturating sums.
// ----------------------------------------------------------------------------
module gpg_datapath #(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  gpg_pkg::gpg_cmd_t cmd,
	output gpg_pkg::gpg_sts_t sts,
	input  logic [2:0] mode,
	input  logic [3*gpg_pkg::COUNT_BITS-1:0] counts,
	input  logic [31:0] origin_x,
	input  logic [31:0] origin_y,
	input  logic [31:0] origin_z,
	input  logic [31:0] step_x,
	input  logic [31:0] step_y,
	input  logic [31:0] step_z,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] pos_z,
	output logic last_vertex
);
	import gpg_pkg::*;

	localparam int unsigned C = COUNT_BITS;
	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);

	logic [C-1:0] outer_q, middle_q, inner_q;
	logic [C-1:0] lim_in, lim_mid, lim_out;
	logic end_in, end_mid, end_out;
	logic [C-1:0] oi, mi, ii;
	logic polar;
	logic [ANGLE_W-1:0] theta_q, phi_q;
	logic signed [TRIG_W-1:0] ct_q, st_q, sp_q, cp_q;
	logic signed [49:0] r_q, a_q, b_q, c_q, ctsp_q, stsp_q;
	logic [31:0] px_q, py_q, pz_q;
	logic last_q;
	logic [16:0] sine_lut [SINE_TABLE_DEPTH+1];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_lut
		localparam longint X = (longint'(k) * 64'sd1686629713) / longint'(SINE_TABLE_DEPTH);
		localparam logic [16:0] ENTRY = sine_entry(X);
		assign sine_lut[k] = ENTRY;
	end

	assign lim_in  = counts[C-1:0];
	assign lim_mid = counts[2*C-1:C];
	assign lim_out = counts[3*C-1:2*C];
	assign ii = cmd.restart ? '0 : inner_q;
	assign mi = cmd.restart ? '0 : middle_q;
	assign oi = cmd.restart ? '0 : outer_q;
	assign end_in  = ii >= lim_in;
	assign end_mid = mi >= lim_mid;
	assign end_out = oi >= lim_out;
	assign polar = (mode == MODE_SPHERE) || (mode == MODE_XY) || (mode == MODE_XZ)
		|| (mode == MODE_YZ);

	function automatic logic signed [TRIG_W-1:0] sine_q16(input logic [ANGLE_W-1:0] a);
		logic [IW-1:0] i;
		logic [16:0] t;
		i = IW'((32'(a[13:0]) * SINE_TABLE_DEPTH) >> 14);
		if (a[14]) begin
			i = IW'(SINE_TABLE_DEPTH) - i;
		end
		t = sine_lut[i];
		return a[15] ? -$signed({1'b0, t}) : $signed({1'b0, t});
	endfunction

	function automatic logic [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) begin
			return 32'h7FFFFFFF;
		end else if (v < -50'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	assign sts.done = (cmd.phase == 3'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= '0;
			middle_q <= '0;
			inner_q <= '0;
		end else if (cmd.start) begin
			if (!end_in) begin
				inner_q <= ii + 1'b1;
				middle_q <= mi;
				outer_q <= oi;
			end else begin
				inner_q <= '0;
				if (!end_mid) begin
					middle_q <= mi + 1'b1;
					outer_q <= oi;
				end else begin
					middle_q <= '0;
					outer_q <= end_out ? '0 : oi + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			last_q <= end_in && end_mid && end_out;
			theta_q <= ANGLE_W'(32'(mi) * 32'(step_y[15:0]));
			phi_q <= ANGLE_W'(32'(oi) * 32'(step_z[15:0]));
			r_q <= 50'(signed'({1'b0, 17'(ii) + 17'd1})) * 50'(signed'(step_x));
			a_q <= 50'(signed'(origin_x)) + 50'(signed'({1'b0, oi})) * 50'(signed'(step_x));
			b_q <= 50'(signed'(origin_y)) + 50'(signed'({1'b0, mi})) * 50'(signed'(step_y));
			c_q <= 50'(signed'(origin_z)) + 50'(signed'({1'b0, ii})) * 50'(signed'(step_z));
		end
		case (cmd.phase)
			3'd0: begin
				ct_q <= sine_q16(theta_q + 16'h4000);
				st_q <= sine_q16(theta_q);
				sp_q <= sine_q16(phi_q);
				cp_q <= sine_q16(phi_q + 16'h4000);
			end
			3'd1: begin
				ctsp_q <= mul_round(50'(ct_q), sp_q);
				stsp_q <= mul_round(50'(st_q), sp_q);
			end
			3'd2: begin
				if (polar) begin
					case (mode)
						MODE_SPHERE: begin
							a_q <= 50'(signed'(origin_x)) + mul_round(r_q, TRIG_W'(ctsp_q));
							b_q <= 50'(signed'(origin_y)) + mul_round(r_q, TRIG_W'(stsp_q));
							c_q <= 50'(signed'(origin_z)) + mul_round(r_q, cp_q);
						end
						MODE_XY: begin
							a_q <= 50'(signed'(origin_x)) + mul_round(r_q, ct_q);
							b_q <= 50'(signed'(origin_y)) + mul_round(r_q, st_q);
							c_q <= 50'(signed'(origin_z));
						end
						MODE_XZ: begin
							a_q <= 50'(signed'(origin_x)) + mul_round(r_q, ct_q);
							b_q <= 50'(signed'(origin_y));
							c_q <= 50'(signed'(origin_z)) + mul_round(r_q, st_q);
						end
						default: begin
							a_q <= 50'(signed'(origin_x));
							b_q <= 50'(signed'(origin_y)) + mul_round(r_q, ct_q);
							c_q <= 50'(signed'(origin_z)) + mul_round(r_q, st_q);
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		if (cmd.phase == 3'd3) begin
			px_q <= sat32(a_q);
			py_q <= sat32(b_q);
			pz_q <= sat32(c_q);
		end
	end

	assign pos_x = px_q;
	assign pos_y = py_q;
	assign pos_z = pz_q;
	assign last_vertex = last_q;
endmodule

### sv/grid_point_generator.sv
// ----------------------------------------------------------------------------
// grid_point_generator
// Lattice vertex generator: box, sphere and circle modes, APB configuration.
// ----------------------------------------------------------------------------
// Each request (tdata bit 0: 1 next vertex, 0 restart) yields one vertex on
// m_tdata {pos_z,pos_y,pos_x} with tlast marking the final vertex. An item
// passes from acceptance through the sine lookup, the two rounding multiply
// steps, the saturating sum and the output handoff to its result; the next
// request is taken the cycle after the result transaction, so a new request
// is never accepted while a result is pending.
module grid_point_generator #(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,  // [0] advance
	output logic m_tvalid,
	input  logic m_tready,
	output logic [95:0] m_tdata, // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
	output logic m_tlast
);
	import gpg_pkg::*;

	logic [2:0] mode_q;
	logic [3*COUNT_BITS-1:0] counts_q;
	logic [31:0] ox_q, oy_q, oz_q, sx_q, sy_q, sz_q;
	gpg_cmd_t cmd;
	gpg_sts_t sts;
	logic wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			counts_q <= '0;
			ox_q <= '0; oy_q <= '0; oz_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_MODE:     mode_q <= pwdata[2:0];
				REG_COUNTS:   counts_q <= pwdata[3*COUNT_BITS-1:0];
				REG_ORIGIN_X: ox_q <= pwdata;
				REG_ORIGIN_Y: oy_q <= pwdata;
				REG_ORIGIN_Z: oz_q <= pwdata;
				REG_STEP_X:   sx_q <= pwdata;
				REG_STEP_Y:   sy_q <= pwdata;
				REG_STEP_Z:   sz_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:     prdata = {29'd0, mode_q};
			REG_COUNTS:   prdata = 32'(counts_q);
			REG_ORIGIN_X: prdata = ox_q;
			REG_ORIGIN_Y: prdata = oy_q;
			REG_ORIGIN_Z: prdata = oz_q;
			REG_STEP_X:   prdata = sx_q;
			REG_STEP_Y:   prdata = sy_q;
			REG_STEP_Z:   prdata = sz_q;
			default:      prdata = '0;
		endcase
	end

	gpg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_advance(s_tdata[0]), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .sts(sts)
	);

	gpg_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode_q), .counts(counts_q),
		.origin_x(ox_q), .origin_y(oy_q), .origin_z(oz_q),
		.step_x(sx_q), .step_y(sy_q), .step_z(sz_q),
		.pos_x(m_tdata[31:0]), .pos_y(m_tdata[63:32]), .pos_z(m_tdata[95:64]),
		.last_vertex(m_tlast)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken while result pending");
	a_out_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");
	a_done_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid) else $error("result not presented");
endmodule
